// ----- sv/jefr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Joint encoder frame receiver package
// Shared constants and types for the frame parser and the result drain.
// ----------------------------------------------------------------------------
package jefr_pkg;

   // Frame start marker.
   localparam logic [7:0] HEADER_BYTE = 8'hAA;

   // Range of identifiers that name a known joint.
   localparam logic [7:0] ID_MIN = 8'h01;
   localparam logic [7:0] ID_MAX = 8'h06;

   // Result status codes.
   localparam logic STATUS_RECORD   = 1'b0;
   localparam logic STATUS_CSUM_ERR = 1'b1;

   // Parser status toward the drain logic.
   typedef struct packed {
      logic at_checksum;   // next byte is the checksum byte
      logic done;          // checksum byte taken in this cycle
      logic csum_ok;       // checksum matched (valid with done)
   } frame_status_type;

endpackage : jefr_pkg
`default_nettype wire

// ----- sv/jefr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Joint encoder frame receiver channels
// Valid/ready channels for received bytes and for decoded results.
// ----------------------------------------------------------------------------
interface jefr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : jefr_req_if

interface jefr_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [7:0]  joint_id;
   logic [15:0] encoder_value;
   logic        id_known;
   logic        last;

   modport source (output valid, output status, output joint_id, output encoder_value,
                   output id_known, output last, input ready);
   modport sink   (input valid, input status, input joint_id, input encoder_value,
                   input id_known, input last, output ready);
endinterface : jefr_rsp_if
`default_nettype wire

// ----- sv/jefr_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Joint encoder frame parser
// Hunts for the header, stores record bytes and checks the additive checksum.
// ----------------------------------------------------------------------------
module jefr_parser #(
   parameter int NUM_RECORDS = 6
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       byte_take,
   input  wire logic [7:0]                 rx_byte,
   output jefr_pkg::frame_status_type      status,
   output logic [7:0]                      record_bytes [3*NUM_RECORDS]
);
   import jefr_pkg::*;

   localparam int REC_BYTES = 3 * NUM_RECORDS;
   localparam int CHECK_POS = REC_BYTES + 1;
   localparam int POS_W     = $clog2(CHECK_POS + 1);
   localparam int BIDX_W    = $clog2(REC_BYTES);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        record_ff [REC_BYTES];
   logic              hunting;
   logic              at_checksum;
   logic              rec_write;
   logic [BIDX_W-1:0] rec_idx;

   assign hunting     = (pos_ff == '0) || (pos_ff > POS_W'(CHECK_POS));
   assign at_checksum = (pos_ff == POS_W'(CHECK_POS));
   assign rec_idx     = BIDX_W'(pos_ff - POS_W'(1));
   assign rec_write   = byte_take && !hunting && !at_checksum;

   // Position and running sum advance by one byte per transfer.
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (byte_take) begin
         if (hunting) begin
            if (rx_byte == HEADER_BYTE) begin
               pos_in = POS_W'(1);
               sum_in = HEADER_BYTE;
            end else begin
               pos_in = '0;
               sum_in = '0;
            end
         end else if (!at_checksum) begin
            pos_in = pos_ff + POS_W'(1);
            sum_in = sum_ff + rx_byte;
         end else begin
            pos_in = '0;
            sum_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Record byte store, written at the current frame position.
   always_ff @(posedge clock) begin
      if (rec_write) begin
         record_ff[rec_idx] <= rx_byte;
      end
   end

   assign record_bytes = record_ff;

   // Status toward the drain logic.
   always_comb begin
      status.at_checksum = at_checksum;
      status.done        = byte_take && at_checksum;
      status.csum_ok     = (sum_ff == rx_byte);
   end

endmodule : jefr_parser
`default_nettype wire

// ----- sv/joint_encoder_frame_receiver.sv -----
`default_nettype none
// Latency: results of a frame appear the cycle after its checksum byte transfer.
// Throughput: one byte per cycle; a good frame then drains NUM_RECORDS results,
// one per cycle when the receiver is ready, while the next frame's bytes keep arriving. Only the next
// checksum byte waits if the previous frame's results are not all taken.
// Reset: synchronous; the block hunts for a header and holds no pending result.
// ----------------------------------------------------------------------------
// Joint encoder frame receiver
// Parses fixed-length header/record/checksum frames and emits joint records.
// ----------------------------------------------------------------------------
module joint_encoder_frame_receiver #(
   parameter int NUM_RECORDS = 6
) (
   input  wire logic   clock,
   input  wire logic   reset,
   jefr_req_if.sink    req_bus,
   jefr_rsp_if.source  rsp_bus
);
   import jefr_pkg::*;

   localparam int REC_BYTES = 3 * NUM_RECORDS;
   localparam int REM_W     = $clog2(NUM_RECORDS + 1);
   localparam int IDX_W     = (NUM_RECORDS > 1) ? $clog2(NUM_RECORDS) : 1;

   frame_status_type  fstat;
   logic [7:0]        record_bytes [REC_BYTES];
   logic              req_take;
   logic              rsp_take;
   logic              busy;

   logic [REM_W-1:0]  remain_ff, remain_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              err_ff, err_in;
   logic [7:0]        id_ff  [NUM_RECORDS];
   logic [15:0]       val_ff [NUM_RECORDS];
   logic [7:0]        cur_id;

   // Input side: only a checksum byte waits for the previous drain to finish.
   assign busy            = (remain_ff != '0);
   assign req_bus.ready   = !(busy && fstat.at_checksum);
   assign req_take        = req_bus.valid && req_bus.ready;
   assign rsp_take        = rsp_bus.valid && rsp_bus.ready;

   jefr_parser #(
      .NUM_RECORDS (NUM_RECORDS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_take    (req_take),
      .rx_byte      (req_bus.rx_byte),
      .status       (fstat),
      .record_bytes (record_bytes)
   );

   // Drain control: load on a finished frame, step on each result transfer.
   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      err_in    = err_ff;
      if (fstat.done) begin
         idx_in = '0;
         if (fstat.csum_ok) begin
            remain_in = REM_W'(NUM_RECORDS);
            err_in    = 1'b0;
         end else begin
            remain_in = REM_W'(1);
            err_in    = 1'b1;
         end
      end else if (rsp_take) begin
         remain_in = remain_ff - REM_W'(1);
         idx_in    = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
         err_ff    <= 1'b0;
      end else begin
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
         err_ff    <= err_in;
      end
   end

   // Snapshot of the frame's records so the next frame can fill the store.
   always_ff @(posedge clock) begin
      if (fstat.done && fstat.csum_ok) begin
         for (int k = 0; k < NUM_RECORDS; k++) begin
            id_ff[k]  <= record_bytes[3*k];
            val_ff[k] <= {record_bytes[3*k+1], record_bytes[3*k+2]};
         end
      end
   end

   // Result fields; an error result carries zeros.
   assign cur_id                = id_ff[idx_ff];
   assign rsp_bus.valid         = busy;
   assign rsp_bus.status        = err_ff ? STATUS_CSUM_ERR : STATUS_RECORD;
   assign rsp_bus.joint_id      = err_ff ? 8'h00 : cur_id;
   assign rsp_bus.encoder_value = err_ff ? 16'h0000 : val_ff[idx_ff];
   assign rsp_bus.id_known      = !err_ff && (cur_id >= ID_MIN) && (cur_id <= ID_MAX);
   assign rsp_bus.last          = (remain_ff == REM_W'(1));

endmodule : joint_encoder_frame_receiver
`default_nettype wire

// ----- tb/tb_joint_encoder_frame_receiver.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Joint encoder frame receiver testbench
// Feeds serial bytes into the frame parser and checks every decoded joint
// record and checksum error against a local frame decoder. A short table of
// extreme bytes and one hand-checked frame comes first, then random frames,
// corrupted frames, noise and cut-off frames with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_joint_encoder_frame_receiver;
   import jefr_pkg::*;

   localparam int NUM_RECORDS  = 6;
   localparam int REC_BYTES    = 3 * NUM_RECORDS;
   localparam int CSUM_POS     = REC_BYTES + 1;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 300;
   localparam int DIR_ROWS_N   = 25;

   // One decoded result as seen on the response channel.
   typedef struct packed {
      logic        status;
      logic [7:0]  joint_id;
      logic [15:0] encoder_value;
      logic        id_known;
      logic        last;
   } joint_result_type;

   // How the results of a table row are obtained.
   typedef enum logic [1:0] {
      ROW_QUIET,       // the byte causes no result
      ROW_PREDICT,     // results come from the frame decoder
      ROW_GOOD_FRAME   // results are the hand-checked records below
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   rx;
   } dir_row_type;

   // Noise after reset, one full frame with extreme ids and values (including a
   // header byte used as data), then near-header bytes that must be dropped.
   localparam dir_row_type DIR_ROWS [0:DIR_ROWS_N-1] = '{
      '{ROW_QUIET, 8'h00}, '{ROW_QUIET, 8'hFF}, '{ROW_QUIET, 8'h55},
      '{ROW_QUIET, 8'hAA},
      '{ROW_QUIET, 8'h00}, '{ROW_QUIET, 8'h00}, '{ROW_QUIET, 8'h00},
      '{ROW_QUIET, 8'h01}, '{ROW_QUIET, 8'hFF}, '{ROW_QUIET, 8'hFF},
      '{ROW_QUIET, 8'h06}, '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'h55},
      '{ROW_QUIET, 8'h07}, '{ROW_QUIET, 8'h80}, '{ROW_QUIET, 8'h01},
      '{ROW_QUIET, 8'hFF}, '{ROW_QUIET, 8'h00}, '{ROW_QUIET, 8'hFF},
      '{ROW_QUIET, 8'hAA}, '{ROW_QUIET, 8'h12}, '{ROW_QUIET, 8'h34},
      '{ROW_GOOD_FRAME, 8'h24},
      '{ROW_QUIET, 8'hAB}, '{ROW_QUIET, 8'hA9}
   };

   // Records of the hand-checked frame above.
   localparam joint_result_type GOOD_FRAME_RECS [0:NUM_RECORDS-1] = '{
      '{STATUS_RECORD, 8'h00, 16'h0000, 1'b0, 1'b0},
      '{STATUS_RECORD, 8'h01, 16'hFFFF, 1'b1, 1'b0},
      '{STATUS_RECORD, 8'h06, 16'hAA55, 1'b1, 1'b0},
      '{STATUS_RECORD, 8'h07, 16'h8001, 1'b0, 1'b0},
      '{STATUS_RECORD, 8'hFF, 16'h00FF, 1'b0, 1'b0},
      '{STATUS_RECORD, 8'hAA, 16'h1234, 1'b0, 1'b1}
   };

   logic clock;
   logic reset;

   jefr_req_if req_bus ();
   jefr_rsp_if rsp_bus ();

   joint_encoder_frame_receiver #(
      .NUM_RECORDS(NUM_RECORDS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Clock with a 12 unit period.
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Frame decoder state.
   logic [4:0]       frame_pos;
   logic [7:0]       frame_sum;
   logic [7:0]       rec_store [0:REC_BYTES-1];
   joint_result_type decoded_rec [0:NUM_RECORDS-1];
   int               decoded_count;

   // Results still owed by the block, oldest first.
   joint_result_type pending_records [$];

   int  fail_count      = 0;
   int  results_checked = 0;
   int  bytes_sent      = 0;
   int  frame_items     = 0;
   int  good_frames     = 0;
   int  bad_frames      = 0;
   int  cycle_count     = 0;
   bit  sender_calm     = 1'b0;
   bit  hold_request    = 1'b0;

   // Advances the frame decoder by one byte and leaves the results it causes
   // in decoded_rec[0 .. decoded_count-1].
   function automatic void decode_byte(input logic [7:0] b);
      int         k;
      logic [7:0] id;
      decoded_count = 0;
      if (frame_pos == 0 || frame_pos > CSUM_POS) begin
         // Hunting: only the header byte starts a frame.
         frame_pos = 0;
         frame_sum = 8'h00;
         if (b == HEADER_BYTE) begin
            frame_sum = HEADER_BYTE;
            frame_pos = 1;
         end
      end else if (frame_pos < CSUM_POS) begin
         // Record byte; a header value here is plain data.
         rec_store[frame_pos - 1] = b;
         frame_sum = frame_sum + b;
         frame_pos = frame_pos + 1;
      end else begin
         // Checksum byte: emit all records or a single error, then hunt again.
         if (frame_sum != b) begin
            decoded_rec[0] = '{STATUS_CSUM_ERR, 8'h00, 16'h0000, 1'b0, 1'b1};
            decoded_count  = 1;
         end else begin
            for (k = 0; k < NUM_RECORDS; k++) begin
               id = rec_store[3 * k];
               decoded_rec[k].status        = STATUS_RECORD;
               decoded_rec[k].joint_id      = id;
               decoded_rec[k].encoder_value = {rec_store[3 * k + 1], rec_store[3 * k + 2]};
               decoded_rec[k].id_known      = (id >= ID_MIN && id <= ID_MAX);
               decoded_rec[k].last          = (k == NUM_RECORDS - 1);
            end
            decoded_count = NUM_RECORDS;
         end
         frame_pos = 0;
         frame_sum = 8'h00;
      end
   endfunction

   // Idle length between transfers: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(6, 30);
   endfunction

   // Record data byte with extra weight on the extremes.
   function automatic logic [7:0] field_byte(input bit aa_heavy);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 8'h00;
      else if (r == 1)
         return 8'hFF;
      else if (r == 2 && aa_heavy)
         return HEADER_BYTE;
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // Offers one byte, waits for its transfer and records what it should cause.
   task automatic send_byte(input logic [7:0] b, input row_kind_type kind);
      int gap;
      int k;
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
      decode_byte(b);
      if (decoded_count == NUM_RECORDS)
         good_frames++;
      else if (decoded_count == 1)
         bad_frames++;
      case (kind)
         ROW_PREDICT: begin
            for (k = 0; k < decoded_count; k++) pending_records.push_back(decoded_rec[k]);
         end
         ROW_GOOD_FRAME: begin
            for (k = 0; k < NUM_RECORDS; k++) pending_records.push_back(GOOD_FRAME_RECS[k]);
         end
         default: ;
      endcase
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         // Idle with junk on the data lines; it must be ignored.
         @(negedge clock);
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'($urandom_range(0, 255));
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Sends one well-formed frame with random content, optionally with a bad
   // checksum.
   task automatic send_frame(input bit corrupt, input bit aa_heavy);
      logic [7:0] sum;
      logic [7:0] b;
      int         k;
      int         j;
      send_byte(HEADER_BYTE, ROW_PREDICT);
      sum = HEADER_BYTE;
      for (k = 0; k < NUM_RECORDS; k++) begin
         for (j = 0; j < 3; j++) begin
            if (j == 0 && $urandom_range(0, 3) != 0)
               b = 8'($urandom_range(0, 8));
            else
               b = field_byte(aa_heavy);
            sum = sum + b;
            send_byte(b, ROW_PREDICT);
         end
      end
      if (corrupt) sum = sum + 8'($urandom_range(1, 255));
      send_byte(sum, ROW_PREDICT);
      frame_items += REC_BYTES + 2;
   endtask

   // Receiver: random stalls, calm stretches, and one long hold-off on request.
   initial begin
      int stall;
      int calm_left;
      int hold_left;
      bit calm;
      stall     = 0;
      calm_left = 0;
      hold_left = 0;
      calm      = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (calm_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 200);
         end else begin
            calm_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < 30) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
            stall--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result transfer with the oldest owed result.
   always @(posedge clock) begin
      joint_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_records.size() == 0) begin
            $error("unexpected result: status %0d joint_id 0x%02h encoder_value 0x%04h",
                   rsp_bus.status, rsp_bus.joint_id, rsp_bus.encoder_value);
            fail_count++;
         end else begin
            want = pending_records.pop_front();
            results_checked++;
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.joint_id !== want.joint_id) begin
               $error("joint_id: expected 0x%02h, actual 0x%02h", want.joint_id,
                      rsp_bus.joint_id);
               fail_count++;
            end
            if (rsp_bus.encoder_value !== want.encoder_value) begin
               $error("encoder_value: expected 0x%04h, actual 0x%04h", want.encoder_value,
                      rsp_bus.encoder_value);
               fail_count++;
            end
            if (rsp_bus.id_known !== want.id_known) begin
               $error("id_known: expected %0d, actual %0d", want.id_known, rsp_bus.id_known);
               fail_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d results still owed.",
                  cycle_count, pending_records.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int i;
      int n;
      int r;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      frame_pos       = 5'd0;
      frame_sum       = 8'h00;
      for (i = 0; i < REC_BYTES; i++) rec_store[i] = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (i = 0; i < DIR_ROWS_N; i++) send_byte(DIR_ROWS[i].rx, DIR_ROWS[i].kind);

      // Back-to-back frames against a long receiver hold-off, so the second
      // frame's checksum has to wait for the first frame's records to drain.
      hold_request = 1'b1;
      sender_calm  = 1'b1;
      for (i = 0; i < 3; i++) send_frame(i == 1, 1'b1);

      // Random mix: mostly frames, some corrupted, plus noise and cut-off frames.
      while (frame_items < RANDOM_ITEMS) begin
         sender_calm = ($urandom_range(0, 4) == 0);
         r = $urandom_range(0, 99);
         if (r < 65) begin
            send_frame(1'b0, $urandom_range(0, 1));
         end else if (r < 80) begin
            send_frame(1'b1, $urandom_range(0, 1));
         end else if (r < 90) begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)), ROW_PREDICT);
         end else begin
            // A frame that breaks off; the following bytes fill its slots.
            n = $urandom_range(1, REC_BYTES);
            send_byte(HEADER_BYTE, ROW_PREDICT);
            for (i = 0; i < n; i++) send_byte(field_byte(1'b1), ROW_PREDICT);
            frame_items += n + 1;
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain, then allow a few quiet cycles for stray results.
      while (pending_records.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d bytes: %0d frames with a good checksum, %0d with a bad one.",
               bytes_sent, good_frames, bad_frames);
      $display("Compared %0d results, including a %0d cycle receiver hold-off.",
               results_checked, HOLD_CYCLES);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule : tb_joint_encoder_frame_receiver
`default_nettype wire
